// ===== rtl/blitc_pkg.sv =====
// ----------------------------------------------------------------------------
// blitc_pkg: shared types and constants for blit rectangle clip setup
// Command and result items, register indexes and the clipped-rectangle bundle.
// ----------------------------------------------------------------------------
package blitc_pkg;

	localparam int MAX_SIDE = 1024;   // largest bitmap side honored
	localparam int SIDE_W   = 11;     // width of a bitmap side register
	localparam int COORD_W  = 12;     // signed corner coordinate
	localparam int POS_W    = 10;     // clipped corner coordinate
	localparam int LEN_W    = 11;     // rectangle size
	localparam int START_W  = 20;     // linear start index
	localparam int SKIP_W   = 10;     // per-row skip

	typedef enum logic [1:0] {
		REG_DEST_WIDTH    = 2'd0,
		REG_DEST_HEIGHT   = 2'd1,
		REG_SOURCE_WIDTH  = 2'd2,
		REG_SOURCE_HEIGHT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] target_col;
		logic signed [COORD_W-1:0] target_row;
		logic signed [COORD_W-1:0] origin_col;
		logic signed [COORD_W-1:0] origin_row;
		logic [LEN_W-1:0]          span_cols;
		logic [LEN_W-1:0]          span_rows;
	} cmd_t;

	typedef struct packed {
		logic               accepted;
		logic [POS_W-1:0]   clip_target_col;
		logic [POS_W-1:0]   clip_target_row;
		logic [POS_W-1:0]   clip_origin_col;
		logic [POS_W-1:0]   clip_origin_row;
		logic [LEN_W-1:0]   clip_cols;
		logic [LEN_W-1:0]   clip_rows;
		logic [START_W-1:0] target_start;
		logic [START_W-1:0] origin_start;
		logic [SKIP_W-1:0]  target_skip;
		logic [SKIP_W-1:0]  origin_skip;
	} res_t;

	// Clipped rectangle handed from the clip stage to the setup stage
	typedef struct packed {
		logic             ok;
		logic [POS_W-1:0] target_col;
		logic [POS_W-1:0] target_row;
		logic [POS_W-1:0] origin_col;
		logic [POS_W-1:0] origin_row;
		logic [LEN_W-1:0] cols;
		logic [LEN_W-1:0] rows;
	} clip_t;

	// Saturate a side register at MAX_SIDE
	function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] r);
		logic [SIDE_W-1:0] lim;
		lim = SIDE_W'(MAX_SIDE);
		return (r > lim) ? lim : r;
	endfunction

endpackage

// ===== rtl/blitc_axis.sv =====
// ----------------------------------------------------------------------------
// blitc_axis: clip one axis of a rectangle against one bitmap side
// Flags rejection, cuts the span at the low and high edges.
// ----------------------------------------------------------------------------
module blitc_axis (
	input  logic signed [blitc_pkg::COORD_W-1:0] pos,
	input  logic [blitc_pkg::LEN_W-1:0]          len,
	input  logic [blitc_pkg::SIDE_W-1:0]         side,
	output logic                                 reject,
	output logic [blitc_pkg::POS_W-1:0]          pos_clip,
	output logic [blitc_pkg::LEN_W-1:0]          len_clip
);

	logic signed [13:0] pos_x;
	logic signed [13:0] len_x;
	logic signed [13:0] side_x;
	logic signed [13:0] sum;
	logic signed [13:0] pos1;
	logic signed [13:0] len1;
	logic signed [13:0] end1;
	logic signed [13:0] len2;

	always_comb begin
		pos_x  = signed'({{2{pos[blitc_pkg::COORD_W-1]}}, pos});
		len_x  = signed'({3'b000, len});
		side_x = signed'({3'b000, side});
		sum    = pos_x + len_x;
		reject = (sum < 14'sd0) || (pos_x >= side_x);

		// cut at the low edge
		if (pos_x < 14'sd0) begin
			pos1 = 14'sd0;
			len1 = sum;
		end else begin
			pos1 = pos_x;
			len1 = len_x;
		end

		// cut at the high edge
		end1 = pos1 + len1;
		if (end1 > side_x) begin
			len2 = side_x - pos1;
		end else begin
			len2 = len1;
		end

		pos_clip = pos1[blitc_pkg::POS_W-1:0];
		len_clip = len2[blitc_pkg::LEN_W-1:0];
	end

endmodule

// ===== rtl/blitc_setup.sv =====
// ----------------------------------------------------------------------------
// blitc_setup: start indexes and row skips for a clipped rectangle
// One row-times-width product per bitmap; rejected rectangles give zeros.
// ----------------------------------------------------------------------------
module blitc_setup (
	input  blitc_pkg::clip_t                     clip,
	input  logic [blitc_pkg::SIDE_W-1:0]         dest_side,
	input  logic [blitc_pkg::SIDE_W-1:0]         source_side,
	output blitc_pkg::res_t                      res
);

	logic [20:0] t_prod;
	logic [20:0] o_prod;
	logic [10:0] t_skip;
	logic [10:0] o_skip;

	always_comb begin
		t_prod = {11'b0, clip.target_row} * {10'b0, dest_side};
		o_prod = {11'b0, clip.origin_row} * {10'b0, source_side};
		t_skip = dest_side - clip.cols;
		o_skip = source_side - clip.cols;

		res = '0;
		if (clip.ok) begin
			res.accepted        = 1'b1;
			res.clip_target_col = clip.target_col;
			res.clip_target_row = clip.target_row;
			res.clip_origin_col = clip.origin_col;
			res.clip_origin_row = clip.origin_row;
			res.clip_cols       = clip.cols;
			res.clip_rows       = clip.rows;
			res.target_start    = t_prod[19:0] + {10'b0, clip.target_col};
			res.origin_start    = o_prod[19:0] + {10'b0, clip.origin_col};
			res.target_skip     = t_skip[9:0];
			res.origin_skip     = o_skip[9:0];
		end
	end

endmodule

// ===== rtl/blit_rect_clip_setup_core.sv =====
// ----------------------------------------------------------------------------
// blit_rect_clip_setup_core: clip a blit rectangle and set up the pixel mover
// Path: the command passes the input, clip and result registers, in that
// order, before the result item is valid.
// Throughput: one item per cycle while results are taken; three stages.
// Reset clears all valid bits and loads every side register with 128.
// ----------------------------------------------------------------------------
module blit_rect_clip_setup_core (
	input  logic                         clk,
	input  logic                         arst_n,

	// configuration write channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [blitc_pkg::SIDE_W-1:0] cfg_data,

	// command channel
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  blitc_pkg::cmd_t              cmd,

	// result channel
	output logic                         res_valid,
	input  logic                         res_ready,
	output blitc_pkg::res_t              res
);

	// ------------------------------------------------------------------
	// Side registers. Writes are taken at any time; software must keep the
	// block idle while it changes them, which the block does not enforce.
	// ------------------------------------------------------------------
	logic [blitc_pkg::SIDE_W-1:0] dest_width_q;
	logic [blitc_pkg::SIDE_W-1:0] dest_height_q;
	logic [blitc_pkg::SIDE_W-1:0] source_width_q;
	logic [blitc_pkg::SIDE_W-1:0] source_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_width_q    <= blitc_pkg::SIDE_W'(128);
			dest_height_q   <= blitc_pkg::SIDE_W'(128);
			source_width_q  <= blitc_pkg::SIDE_W'(128);
			source_height_q <= blitc_pkg::SIDE_W'(128);
		end else if (cfg_valid) begin
			case (blitc_pkg::reg_idx_t'(cfg_index))
				blitc_pkg::REG_DEST_WIDTH:    dest_width_q    <= cfg_data;
				blitc_pkg::REG_DEST_HEIGHT:   dest_height_q   <= cfg_data;
				blitc_pkg::REG_SOURCE_WIDTH:  source_width_q  <= cfg_data;
				blitc_pkg::REG_SOURCE_HEIGHT: source_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sides above the supported maximum act as the maximum
	logic [blitc_pkg::SIDE_W-1:0] dw;
	logic [blitc_pkg::SIDE_W-1:0] dh;
	logic [blitc_pkg::SIDE_W-1:0] sw;
	logic [blitc_pkg::SIDE_W-1:0] sh;

	assign dw = blitc_pkg::eff_side(dest_width_q);
	assign dh = blitc_pkg::eff_side(dest_height_q);
	assign sw = blitc_pkg::eff_side(source_width_q);
	assign sh = blitc_pkg::eff_side(source_height_q);

	// ------------------------------------------------------------------
	// Pipeline flow control. Each stage advances when it is empty or the
	// stage after it advances, so bubbles fill and a full pipe accepts a
	// new item every cycle while the result is taken.
	// ------------------------------------------------------------------
	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic en1;
	logic en2;
	logic en3;

	assign en3       = !v_s3 || res_ready;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign cmd_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= cmd_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: capture the command
	// ------------------------------------------------------------------
	blitc_pkg::cmd_t cmd_s1;

	always_ff @(posedge clk) begin
		if (en1 && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	// ------------------------------------------------------------------
	// Clip against the source bitmap, then against the destination with
	// the already cut size. A low-edge cut on one bitmap moves only that
	// bitmap's corner.
	// ------------------------------------------------------------------
	logic                          rej_sx;
	logic                          rej_sy;
	logic                          rej_dx;
	logic                          rej_dy;
	logic [blitc_pkg::POS_W-1:0]   src_col;
	logic [blitc_pkg::POS_W-1:0]   src_row;
	logic [blitc_pkg::LEN_W-1:0]   src_cols;
	logic [blitc_pkg::LEN_W-1:0]   src_rows;
	logic [blitc_pkg::POS_W-1:0]   dst_col;
	logic [blitc_pkg::POS_W-1:0]   dst_row;
	logic [blitc_pkg::LEN_W-1:0]   dst_cols;
	logic [blitc_pkg::LEN_W-1:0]   dst_rows;
	blitc_pkg::clip_t              clip_d;

	blitc_axis u_src_x (
		.pos      (cmd_s1.origin_col),
		.len      (cmd_s1.span_cols),
		.side     (sw),
		.reject   (rej_sx),
		.pos_clip (src_col),
		.len_clip (src_cols)
	);

	blitc_axis u_src_y (
		.pos      (cmd_s1.origin_row),
		.len      (cmd_s1.span_rows),
		.side     (sh),
		.reject   (rej_sy),
		.pos_clip (src_row),
		.len_clip (src_rows)
	);

	blitc_axis u_dst_x (
		.pos      (cmd_s1.target_col),
		.len      (src_cols),
		.side     (dw),
		.reject   (rej_dx),
		.pos_clip (dst_col),
		.len_clip (dst_cols)
	);

	blitc_axis u_dst_y (
		.pos      (cmd_s1.target_row),
		.len      (src_rows),
		.side     (dh),
		.reject   (rej_dy),
		.pos_clip (dst_row),
		.len_clip (dst_rows)
	);

	// Destination values only matter when the source clip passed; any
	// rejection zeroes the whole result downstream.
	always_comb begin
		clip_d.ok         = !(rej_sx || rej_sy || rej_dx || rej_dy);
		clip_d.target_col = dst_col;
		clip_d.target_row = dst_row;
		clip_d.origin_col = src_col;
		clip_d.origin_row = src_row;
		clip_d.cols       = dst_cols;
		clip_d.rows       = dst_rows;
	end

	// ------------------------------------------------------------------
	// Stage 2: hold the clipped rectangle
	// ------------------------------------------------------------------
	blitc_pkg::clip_t clip_s2;

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			clip_s2 <= clip_d;
		end
	end

	// ------------------------------------------------------------------
	// Start indexes and skips, then the result register
	// ------------------------------------------------------------------
	blitc_pkg::res_t res_d;
	blitc_pkg::res_t res_s3;

	blitc_setup u_setup (
		.clip        (clip_s2),
		.dest_side   (dw),
		.source_side (sw),
		.res         (res_d)
	);

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			res_s3 <= res_d;
		end
	end

	assign res_valid = v_s3;
	assign res       = res_s3;

endmodule

// ===== tb/sv/blit_rect_clip_setup_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blit_rect_clip_setup_check: result predictor and comparator
// Watches the side-register, command and result channels. Keeps its own copy
// of the bitmap sides, predicts the setup item for every accepted command and
// compares each accepted result item, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module blit_rect_clip_setup_check (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [blitc_pkg::SIDE_W-1:0] cfg_data,

	input  logic                         cmd_valid,
	input  logic                         cmd_ready,
	input  blitc_pkg::cmd_t              cmd,

	input  logic                         res_valid,
	input  logic                         res_ready,
	input  blitc_pkg::res_t              res,

	output int                           fail_count,
	output int                           pending_count,
	output int                           result_count,
	output int                           accept_count
);

	import blitc_pkg::*;

	logic [SIDE_W-1:0] dst_w, dst_h, src_w, src_h;
	res_t              expected_setups[$];
	res_t              want;
	int                mismatch_total;
	int                result_total;
	int                accept_total;

	function automatic int side_limit(input logic [SIDE_W-1:0] r);
		return (int'(r) > MAX_SIDE) ? MAX_SIDE : int'(r);
	endfunction

	// Clip one rectangle against a bitmap; return 0 when it lies wholly outside
	function automatic bit clip_rect(inout int x, inout int y, inout int w, inout int h,
			input int bw, input int bh);
		if (x + w < 0 || y + h < 0 || x >= bw || y >= bh)
			return 1'b0;
		if (x < 0) begin
			w = w + x;
			x = 0;
		end
		if (y < 0) begin
			h = h + y;
			y = 0;
		end
		if (x + w > bw)
			w = bw - x;
		if (y + h > bh)
			h = bh - y;
		return 1'b1;
	endfunction

	function automatic res_t predict_setup(input cmd_t c);
		int   tx, ty, ox, oy, w, h, dw, dh, sw, sh;
		res_t r;
		r  = '0;
		tx = int'(c.target_col);
		ty = int'(c.target_row);
		ox = int'(c.origin_col);
		oy = int'(c.origin_row);
		w  = int'(c.span_cols);
		h  = int'(c.span_rows);
		dw = side_limit(dst_w);
		dh = side_limit(dst_h);
		sw = side_limit(src_w);
		sh = side_limit(src_h);
		// source first, then destination with the size already cut
		if (!clip_rect(ox, oy, w, h, sw, sh))
			return r;
		if (!clip_rect(tx, ty, w, h, dw, dh))
			return r;
		r.accepted        = 1'b1;
		r.clip_target_col = POS_W'(tx);
		r.clip_target_row = POS_W'(ty);
		r.clip_origin_col = POS_W'(ox);
		r.clip_origin_row = POS_W'(oy);
		r.clip_cols       = LEN_W'(w);
		r.clip_rows       = LEN_W'(h);
		r.target_start    = START_W'(ty * dw + tx);
		r.origin_start    = START_W'(oy * sw + ox);
		r.target_skip     = SKIP_W'(dw - w);
		r.origin_skip     = SKIP_W'(sw - w);
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			mismatch_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_w          = 11'd128;
			dst_h          = 11'd128;
			src_w          = 11'd128;
			src_h          = 11'd128;
			expected_setups.delete();
			mismatch_total = 0;
			result_total   = 0;
			accept_total   = 0;
			fail_count    <= 0;
			pending_count <= 0;
			result_count  <= 0;
			accept_count  <= 0;
		end else begin
			if (res_valid && res_ready) begin
				result_total++;
				if (res.accepted)
					accept_total++;
				if (expected_setups.size() == 0) begin
					$error("result item with no command outstanding");
					mismatch_total++;
				end else begin
					want = expected_setups.pop_front();
					check_field("accepted", 32'(want.accepted), 32'(res.accepted));
					check_field("clip_target_col", 32'(want.clip_target_col),
						32'(res.clip_target_col));
					check_field("clip_target_row", 32'(want.clip_target_row),
						32'(res.clip_target_row));
					check_field("clip_origin_col", 32'(want.clip_origin_col),
						32'(res.clip_origin_col));
					check_field("clip_origin_row", 32'(want.clip_origin_row),
						32'(res.clip_origin_row));
					check_field("clip_cols", 32'(want.clip_cols), 32'(res.clip_cols));
					check_field("clip_rows", 32'(want.clip_rows), 32'(res.clip_rows));
					check_field("target_start", 32'(want.target_start),
						32'(res.target_start));
					check_field("origin_start", 32'(want.origin_start),
						32'(res.origin_start));
					check_field("target_skip", 32'(want.target_skip),
						32'(res.target_skip));
					check_field("origin_skip", 32'(want.origin_skip),
						32'(res.origin_skip));
				end
			end
			if (cmd_valid && cmd_ready)
				expected_setups.push_back(predict_setup(cmd));
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_DEST_WIDTH:    dst_w = cfg_data;
					REG_DEST_HEIGHT:   dst_h = cfg_data;
					REG_SOURCE_WIDTH:  src_w = cfg_data;
					REG_SOURCE_HEIGHT: src_h = cfg_data;
					default: ;
				endcase
			end
			fail_count    <= mismatch_total;
			pending_count <= expected_setups.size();
			result_count  <= result_total;
			accept_count  <= accept_total;
		end
	end

endmodule

// ===== tb/sv/blit_rect_clip_setup_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blit_rect_clip_setup_core_tb: testbench top for the blit clip setup core
// Drives bitmap sides and blit commands with random idling and stalls, lets
// the attached checker predict and compare every setup item, and reports.
// ----------------------------------------------------------------------------
module blit_rect_clip_setup_core_tb;

	import blitc_pkg::*;

	localparam int PHASES     = 6;     // side settings, two fixed then random
	localparam int PHASE_CMDS = 250;   // commands per setting
	localparam int HOLD_CYCLES = 200;  // long receiver hold-off
	localparam int DRAIN_CYCLES = 8;   // extra wait once nothing is pending

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [SIDE_W-1:0] cfg_data;
	logic              cmd_valid;
	logic              cmd_ready;
	cmd_t              cmd_item;
	logic              res_valid;
	logic              res_ready;
	res_t              res_item;

	int fail_count, pending_count, result_count, accept_count;
	int snd_idle_pct;
	int rcv_idle_pct;
	int cmds_sent;
	int side_writes;
	int cur_side [4];
	bit hold_req = 1'b0;

	blit_rect_clip_setup_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res_item)
	);

	blit_rect_clip_setup_check u_setup_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd_item),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res_item),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.result_count  (result_count),
		.accept_count  (accept_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#2000000;
		$display("blit_rect_clip_setup_core_tb: FAIL");
		$finish;
	end

	// Receiver: random stalls at the current rate; on request hold off for a
	// long stretch so the pipeline fills and backs up into the command channel
	initial begin
		res_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			res_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	function automatic cmd_t mk_cmd(input int tcol, input int trow, input int ocol,
			input int orow, input int wcols, input int hrows);
		cmd_t c;
		c.target_col = COORD_W'(tcol);
		c.target_row = COORD_W'(trow);
		c.origin_col = COORD_W'(ocol);
		c.origin_row = COORD_W'(orow);
		c.span_cols  = LEN_W'(wcols);
		c.span_rows  = LEN_W'(hrows);
		return c;
	endfunction

	// Range used to aim corners and sizes at the current bitmaps
	function automatic int shape_lim(input int v);
		if (v == 0)
			return 16;
		return (v > MAX_SIDE) ? MAX_SIDE : v;
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord(input int lim);
		int v;
		case ($urandom_range(9))
			0, 1:    v = int'($urandom_range(4095)) - 2048;        // anywhere
			2:       v = lim - 2 + int'($urandom_range(3));        // far edge
			3:       v = int'($urandom_range(3)) - 2;              // near edge
			default: v = int'($urandom_range(lim + 63)) - 32;      // around the bitmap
		endcase
		return COORD_W'(v);
	endfunction

	function automatic logic [LEN_W-1:0] rand_span(input int lim);
		case ($urandom_range(9))
			0:       return LEN_W'($urandom_range(2047));
			1:       return '0;
			2, 3, 4: return LEN_W'($urandom_range(32, 1));
			default: return LEN_W'($urandom_range(lim + 32, 1));
		endcase
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int   dl_c, dl_r, sl_c, sl_r;
		dl_c = shape_lim(cur_side[REG_DEST_WIDTH]);
		dl_r = shape_lim(cur_side[REG_DEST_HEIGHT]);
		sl_c = shape_lim(cur_side[REG_SOURCE_WIDTH]);
		sl_r = shape_lim(cur_side[REG_SOURCE_HEIGHT]);
		c.target_col = rand_coord(dl_c);
		c.target_row = rand_coord(dl_r);
		c.origin_col = rand_coord(sl_c);
		c.origin_row = rand_coord(sl_r);
		c.span_cols  = rand_span((dl_c > sl_c) ? dl_c : sl_c);
		c.span_rows  = rand_span((dl_r > sl_r) ? dl_r : sl_r);
		// now and then touch the left or top edge from outside
		case ($urandom_range(19))
			0: c.origin_col = COORD_W'(-int'(c.span_cols));
			1: c.target_row = COORD_W'(-int'(c.span_rows));
			default: ;
		endcase
		return c;
	endfunction

	function automatic logic [SIDE_W-1:0] rand_side();
		case ($urandom_range(9))
			0:       return '0;
			1:       return SIDE_W'(1);
			2:       return SIDE_W'(MAX_SIDE);
			3:       return SIDE_W'(2047);
			4:       return SIDE_W'($urandom_range(2047, MAX_SIDE + 1));
			5, 6:    return SIDE_W'($urandom_range(64, 1));
			default: return SIDE_W'($urandom_range(MAX_SIDE, 1));
		endcase
	endfunction

	// Offer one command, idling first at the sender's rate; hold it until taken
	task automatic send_cmd(input cmd_t c);
		while ($urandom_range(99) < snd_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item  <= c;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		cmds_sent++;
	endtask

	// Drop valid and wait until every outstanding setup item has come back
	task automatic quiesce();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_count != 0);
	endtask

	// Write one side register; valid stays high for a following write
	task automatic write_side(input reg_idx_t idx, input logic [SIDE_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cur_side[idx] = int'(val);
		side_writes++;
	endtask

	task automatic set_sides(input logic [SIDE_W-1:0] dw, input logic [SIDE_W-1:0] dh,
			input logic [SIDE_W-1:0] sw, input logic [SIDE_W-1:0] sh);
		quiesce();
		write_side(REG_DEST_WIDTH, dw);
		write_side(REG_DEST_HEIGHT, dh);
		write_side(REG_SOURCE_WIDTH, sw);
		write_side(REG_SOURCE_HEIGHT, sh);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		cmd_valid    = 1'b0;
		cmd_item     = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		arst_n       = 1'b0;
		snd_idle_pct = 11;
		rcv_idle_pct = 48;
		cmds_sent    = 0;
		side_writes  = 0;
		foreach (cur_side[i])
			cur_side[i] = 128;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed commands against the 128 x 128 reset bitmaps
		send_cmd(mk_cmd(0, 0, 0, 0, 16, 16));                 // plain copy
		send_cmd(mk_cmd(-2048, -2048, -2048, -2048, 2047, 2047)); // far left, reject
		send_cmd(mk_cmd(2047, 2047, 2047, 2047, 2047, 2047)); // far right, reject
		send_cmd(mk_cmd(0, 0, 0, 0, 2047, 2047));             // cut to bitmap
		send_cmd(mk_cmd(-10, -5, 0, 0, 20, 20));              // dest cut, source stays
		send_cmd(mk_cmd(0, 0, -10, -5, 20, 20));              // source cut
		send_cmd(mk_cmd(0, 0, -16, 0, 16, 8));                // touches left edge: empty
		send_cmd(mk_cmd(0, 0, 0, 0, 0, 0));                   // zero span
		send_cmd(mk_cmd(127, 127, 127, 127, 5, 5));           // last pixel
		send_cmd(mk_cmd(128, 0, 0, 0, 4, 4));                 // dest column at width
		send_cmd(mk_cmd(0, 0, 0, 128, 4, 4));                 // source row at height
		send_cmd(mk_cmd(-2048, 0, 0, 0, 2047, 4));            // dest reject after source cut
		send_cmd(mk_cmd(0, -4, 0, 0, 10, 4));                 // touches top edge: empty

		// Full-size and oversized sides: skip wraps to zero on a zero width
		set_sides(SIDE_W'(MAX_SIDE), SIDE_W'(MAX_SIDE), SIDE_W'(2047), SIDE_W'(MAX_SIDE));
		send_cmd(mk_cmd(0, 0, 0, 0, 0, 0));
		send_cmd(mk_cmd(1000, 1000, 1000, 1000, 100, 100));
		send_cmd(mk_cmd(0, 0, 0, 0, 2047, 2047));
		send_cmd(mk_cmd(1023, 1023, 1023, 1023, 1, 1));

		// Zero-width destination: only negative corners survive, with size zero
		set_sides('0, SIDE_W'(MAX_SIDE), SIDE_W'(MAX_SIDE), SIDE_W'(MAX_SIDE));
		send_cmd(mk_cmd(-4, 0, 0, 0, 10, 10));
		send_cmd(mk_cmd(0, 0, 0, 0, 10, 10));

		// Zero-height source
		set_sides(SIDE_W'(MAX_SIDE), SIDE_W'(MAX_SIDE), SIDE_W'(MAX_SIDE), '0);
		send_cmd(mk_cmd(0, 0, 0, -3, 5, 5));
		send_cmd(mk_cmd(0, 0, 0, 0, 5, 5));

		// Random commands over several side settings and idling patterns
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0)
				set_sides(SIDE_W'(1), SIDE_W'(1), SIDE_W'(1), SIDE_W'(1));
			else if (ph == 1)
				set_sides(SIDE_W'(MAX_SIDE), SIDE_W'(MAX_SIDE), SIDE_W'(MAX_SIDE),
					SIDE_W'(MAX_SIDE));
			else
				set_sides(rand_side(), rand_side(), rand_side(), rand_side());
			case (ph / 2)
				0: begin
					snd_idle_pct = 11;
					rcv_idle_pct = 48;
				end
				1: begin
					snd_idle_pct = 48;
					rcv_idle_pct = 11;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < PHASE_CMDS; n++) begin
				// stall the receiver while commands keep coming
				if (ph == 2 && n == 100)
					hold_req = 1'b1;
				// pause the sender until the pipeline has drained
				if (ph == 3 && n == 125)
					quiesce();
				send_cmd(rand_cmd());
			end
		end

		quiesce();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d commands and %0d side writes, incl. zero and oversized sides",
			cmds_sent, side_writes);
		$display("checked %0d setup items: %0d accepted, %0d rejected",
			result_count, accept_count, result_count - accept_count);
		if (pending_count != 0)
			$error("%0d setup items never arrived", pending_count);
		if (fail_count == 0 && pending_count == 0)
			$display("blit_rect_clip_setup_core_tb: PASS");
		else
			$display("blit_rect_clip_setup_core_tb: FAIL");
		$finish;
	end

endmodule
